// ===== rtl/core/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 step for the humidity/temperature
// frame decoder. No dependencies; used by every module of the block.
package htfd_pkg;

	// Result status codes as carried in the low bits of the result transfer.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BUSY = 2'd1,
		ST_CRC  = 2'd2,
		ST_INIT = 2'd3
	} status_t;

	localparam int unsigned RAW_W   = 20;
	localparam int unsigned HUM_W   = 14;
	localparam int unsigned TEMP_W  = 15;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned OUT_W   = 72;

	localparam logic [7:0] CRC_POLY   = 8'h31;
	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [7:0] READY_MASK = 8'h18;
	localparam logic [2:0] FRAME_DATA = 3'd6;

	localparam logic [13:0] HUM_SCALE  = 14'd10000;
	localparam logic [14:0] TEMP_SCALE = 15'd20000;
	localparam logic [15:0] TEMP_OFFS  = 16'd5000;

	// Finished frame outcome handed from the frame tracker to the scaler.
	typedef struct packed {
		logic             valid;
		status_t          code;
		logic [RAW_W-1:0] hum_raw;
		logic [RAW_W-1:0] temp_raw;
	} frame_res_t;

	// One byte of CRC-8, MSB first, unrolled over the eight bit steps.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/htfd_frame.sv =====
// Frame tracker: arming, byte counting, running CRC and data capture.
// Depends on htfd_pkg for the CRC step, codes and the result struct.
module htfd_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 command,
	input  logic [7:0]           data_byte,
	output htfd_pkg::frame_res_t res
);

	logic                             armed_q;
	logic [2:0]                       count_q;
	logic [7:0]                       crc_q;
	logic                             busy_q;
	logic [htfd_pkg::FRAME_W-1:0]     data_q;
	logic                             ready_byte;
	logic                             last_byte;

	assign ready_byte = (data_byte & htfd_pkg::READY_MASK) == htfd_pkg::READY_MASK;
	assign last_byte  = armed_q && (count_q >= htfd_pkg::FRAME_DATA);

	// Outcome of the byte in the input register, valid only when a result is due.
	always_comb begin
		res          = '0;
		res.code     = htfd_pkg::ST_OK;
		res.hum_raw  = data_q[htfd_pkg::FRAME_W-1:htfd_pkg::RAW_W];
		res.temp_raw = data_q[htfd_pkg::RAW_W-1:0];
		if (!command) begin
			res.valid = !ready_byte;
			res.code  = htfd_pkg::ST_INIT;
		end else if (last_byte) begin
			res.valid = 1'b1;
			if (busy_q) begin
				res.code = htfd_pkg::ST_BUSY;
			end else if (crc_q != data_byte) begin
				res.code = htfd_pkg::ST_CRC;
			end else begin
				res.code = htfd_pkg::ST_OK;
			end
		end
	end

	// Control state: a status byte restarts the frame, the seventh byte closes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			count_q <= '0;
			crc_q   <= htfd_pkg::CRC_INIT;
			busy_q  <= 1'b0;
		end else if (step) begin
			if (!command || last_byte) begin
				armed_q <= !command && ready_byte;
				count_q <= '0;
				crc_q   <= htfd_pkg::CRC_INIT;
				busy_q  <= 1'b0;
			end else if (armed_q) begin
				count_q <= count_q + 3'd1;
				crc_q   <= htfd_pkg::crc8_byte(crc_q, data_byte);
				if (count_q == 3'd0) begin
					busy_q <= data_byte[7];
				end
			end
		end
	end

	// Data bytes shift in; five of them replace the whole word, so no clearing.
	always_ff @(posedge clk) begin
		if (step && command && armed_q && !last_byte && (count_q != 3'd0)) begin
			data_q <= {data_q[htfd_pkg::FRAME_W-9:0], data_byte};
		end
	end

endmodule

// ===== rtl/core/htfd_scale.sv =====
// Result formatter: scales the raw fields to hundredths and packs the transfer.
// Depends on htfd_pkg for field widths, scale constants and the result struct.
module htfd_scale (
	input  htfd_pkg::frame_res_t          res,
	output logic [htfd_pkg::OUT_W-1:0]    payload
);

	logic [33:0]                      hum_prod;
	logic [34:0]                      temp_prod;
	logic [15:0]                      temp_diff;
	logic [htfd_pkg::HUM_W-1:0]       hum_centi;
	logic signed [htfd_pkg::TEMP_W-1:0] temp_centi;
	logic                             ok;

	// One constant multiply per field, then a shift by twenty and the offset.
	assign hum_prod   = {14'd0, res.hum_raw} * {20'd0, htfd_pkg::HUM_SCALE};
	assign temp_prod  = {15'd0, res.temp_raw} * {20'd0, htfd_pkg::TEMP_SCALE};
	assign hum_centi  = hum_prod[33:20];
	assign temp_diff  = {1'b0, temp_prod[34:20]} - htfd_pkg::TEMP_OFFS;
	assign temp_centi = signed'(temp_diff[14:0]);
	assign ok         = res.code == htfd_pkg::ST_OK;

	// Pack from the lowest bit up; non-ok results carry zero values.
	always_comb begin
		payload        = '0;
		payload[1:0]   = res.code;
		if (ok) begin
			payload[21:2]  = res.hum_raw;
			payload[41:22] = res.temp_raw;
			payload[55:42] = hum_centi;
			payload[70:56] = temp_centi;
		end
	end

endmodule

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
// Top level of the humidity/temperature frame decoder: input register,
// frame tracker, formatter and result register. Depends on htfd_pkg.
//
// The decoder takes one byte in every cycle while the input side is not
// stalled. A byte waits in the input register, where the frame tracker and
// the formatter work on it. When the byte causes a result, the result is
// loaded into the result register at the clock edge at which the byte leaves
// the input register, and is shown from that edge until it is taken. The input side
// stalls only when both registers are full and the result is not being taken.
// Status bytes travel with tuser low, frame bytes with tuser high.
module humidity_temp_frame_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // data_byte[7:0]
	input  logic                      s_tuser,  // command
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [htfd_pkg::OUT_W-1:0] m_tdata  // status_code[1:0], humidity_raw[21:2],
	                                            // temperature_raw[41:22],
	                                            // humidity_centi[55:42],
	                                            // temperature_centi[70:56], zero pad[71]
);

	logic                           valid_s1;
	logic                           cmd_s1;
	logic [7:0]                     byte_s1;
	logic                           valid_s2;
	logic [htfd_pkg::OUT_W-1:0]     data_s2;
	logic                           adv;
	logic                           step;
	htfd_pkg::frame_res_t           res;
	logic [htfd_pkg::OUT_W-1:0]     payload;

	// The input register moves on whenever the result register is free or emptying.
	assign adv      = !valid_s2 || m_tready;
	assign step     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	htfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.command   (cmd_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	htfd_scale u_scale (
		.res     (res),
		.payload (payload)
	);

	// Valid flags of both registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= step && res.valid;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (step && res.valid) begin
			data_s2 <= payload;
		end
	end

	// A non-ok result carries nothing but its status code.
	a_nonok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != htfd_pkg::ST_OK) |-> (m_tdata[71:2] == '0))
		else $error("non-ok result with non-zero fields");

	// Scaled humidity stays below one hundred percent.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:42] <= 14'd9999))
		else $error("humidity out of range");

	// The input side stalls only when both registers are full and the output is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled without cause");

	// A result taken with nothing behind it leaves the result register empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !valid_s1 |=> !m_tvalid)
		else $error("result repeated");

endmodule

// ===== sim/htfd_frame_checker.sv =====
// Checker for the humidity/temperature frame decoder: follows input and result
// transfers, predicts every result and compares field by field.
// Depends on htfd_pkg for the status codes, widths and constants.
module htfd_frame_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [7:0]                 s_tdata,
	input  logic                       s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [htfd_pkg::OUT_W-1:0] m_tdata,
	output int                         errors,
	output int                         pending,
	output int                         n_ok,
	output int                         n_busy,
	output int                         n_crc,
	output int                         n_init
);

	// One decoded reading as it should appear on the result side.
	typedef struct packed {
		htfd_pkg::status_t             code;
		logic [htfd_pkg::RAW_W-1:0]    hum_raw;
		logic [htfd_pkg::RAW_W-1:0]    temp_raw;
		logic [htfd_pkg::HUM_W-1:0]    hum_centi;
		logic [htfd_pkg::TEMP_W-1:0]   temp_centi;
	} reading_t;

	reading_t readings_due[$];

	// Predicted decoder state.
	logic        frame_armed = 1'b0;
	logic [2:0]  frame_pos   = '0;
	logic [7:0]  crc_run     = htfd_pkg::CRC_INIT;
	logic [7:0]  state_hold  = '0;
	logic [39:0] payload     = '0;

	int err_cnt = 0;
	int cnt_ok = 0, cnt_busy = 0, cnt_crc = 0, cnt_init = 0;

	assign errors  = err_cnt;
	assign pending = readings_due.size();
	assign n_ok    = cnt_ok;
	assign n_busy  = cnt_busy;
	assign n_crc   = cnt_crc;
	assign n_init  = cnt_init;

	// CRC-8 over one byte, most significant bit first.
	function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			fb = c[7];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ htfd_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	// Builds the expected reading; anything but an ok result carries zeros.
	function automatic reading_t make_reading(input htfd_pkg::status_t code,
			input logic [htfd_pkg::RAW_W-1:0] h, input logic [htfd_pkg::RAW_W-1:0] t);
		reading_t    r;
		longint      hc;
		longint      tc;
		r      = '0;
		r.code = code;
		if (code == htfd_pkg::ST_OK) begin
			hc           = (longint'(h) * 10000) >>> 20;
			tc           = ((longint'(t) * 20000) >>> 20) - 5000;
			r.hum_raw    = h;
			r.temp_raw   = t;
			r.hum_centi  = hc[htfd_pkg::HUM_W-1:0];
			r.temp_centi = tc[htfd_pkg::TEMP_W-1:0];
		end
		return r;
	endfunction

	task automatic clear_frame();
		frame_pos  = '0;
		crc_run    = htfd_pkg::CRC_INIT;
		state_hold = '0;
		payload    = '0;
	endtask

	// Advances the predicted state by one accepted input byte.
	task automatic take_byte(input logic cmd, input logic [7:0] b);
		htfd_pkg::status_t code;
		if (!cmd) begin
			clear_frame();
			if ((b & htfd_pkg::READY_MASK) == htfd_pkg::READY_MASK) begin
				frame_armed = 1'b1;
			end else begin
				frame_armed = 1'b0;
				readings_due.push_back(make_reading(htfd_pkg::ST_INIT, '0, '0));
			end
		end else if (frame_armed) begin
			if (frame_pos < htfd_pkg::FRAME_DATA) begin
				crc_run = crc_next(crc_run, b);
				if (frame_pos == 3'd0) begin
					state_hold = b;
				end else begin
					payload = {payload[31:0], b};
				end
				frame_pos = frame_pos + 3'd1;
			end else begin
				// The busy flag outranks a CRC mismatch.
				if (state_hold[7]) begin
					code = htfd_pkg::ST_BUSY;
				end else if (crc_run != b) begin
					code = htfd_pkg::ST_CRC;
				end else begin
					code = htfd_pkg::ST_OK;
				end
				readings_due.push_back(make_reading(code, payload[39:20], payload[19:0]));
				frame_armed = 1'b0;
				clear_frame();
			end
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		if (err_cnt < 30) begin
			$display("mismatch at %0t: %s got %0d, wanted %0d", $realtime, what, got, want);
		end
		err_cnt++;
	endtask

	// Compares one result transfer with the oldest reading still due.
	task automatic check_result(input logic [htfd_pkg::OUT_W-1:0] d);
		reading_t want;
		if (readings_due.size() == 0) begin
			report("result with nothing due, status", d[1:0], -1);
		end else begin
			want = readings_due.pop_front();
			case (want.code)
				htfd_pkg::ST_OK:   cnt_ok++;
				htfd_pkg::ST_BUSY: cnt_busy++;
				htfd_pkg::ST_CRC:  cnt_crc++;
				default:           cnt_init++;
			endcase
			if (d[1:0] != want.code) begin
				report("status_code", d[1:0], want.code);
			end
			if (d[21:2] != want.hum_raw) begin
				report("humidity_raw", d[21:2], want.hum_raw);
			end
			if (d[41:22] != want.temp_raw) begin
				report("temperature_raw", d[41:22], want.temp_raw);
			end
			if (d[55:42] != want.hum_centi) begin
				report("humidity_centi", d[55:42], want.hum_centi);
			end
			if (d[70:56] != want.temp_centi) begin
				report("temperature_centi", longint'($signed(d[70:56])),
					longint'($signed(want.temp_centi)));
			end
			if (d[71] != 1'b0) begin
				report("pad bit", d[71], 0);
			end
		end
	endtask

	// Both channels are sampled at the same edge at which the DUT sees them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_armed = 1'b0;
			clear_frame();
			readings_due.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				take_byte(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
			end
		end
	end

endmodule

// ===== sim/tb.sv =====
// Top of the frame decoder testbench: clock, reset, byte stimulus, result-side
// back-pressure and the verdict. Depends on htfd_pkg, the decoder and
// htfd_frame_checker.
module tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 64;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [7:0]                 s_tdata;
	logic                       s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [htfd_pkg::OUT_W-1:0] m_tdata;

	int s_idle_pct  = 0;
	int m_stall_pct = 0;
	int hold_req    = 0;
	int bytes_sent  = 0;
	int quiet       = 0;

	int errors, pending, n_ok, n_busy, n_crc, n_init;

	humidity_temp_frame_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	htfd_frame_checker i_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.n_ok     (n_ok),
		.n_busy   (n_busy),
		.n_crc    (n_crc),
		.n_init   (n_init)
	);

	always #5 clk = ~clk;

	// Status byte with both ready bits set and the rest random.
	function automatic logic [7:0] ready_byte();
		return 8'($urandom_range(255)) | htfd_pkg::READY_MASK;
	endfunction

	// Status byte with at least one ready bit clear.
	function automatic logic [7:0] not_ready_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if ((b & htfd_pkg::READY_MASK) == htfd_pkg::READY_MASK) begin
			if ($urandom_range(1) == 0) begin
				b[3] = 1'b0;
			end else begin
				b[4] = 1'b0;
			end
		end
		return b;
	endfunction

	// Data bytes lean towards the range ends so the scaled values hit them.
	function automatic logic [7:0] payload_byte();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return 8'h00;
		end else if (pick == 1) begin
			return 8'hFF;
		end
		return 8'($urandom_range(255));
	endfunction

	// Offers one byte, with a random idle gap first, and waits for its transfer.
	task automatic send_byte(input logic cmd, input logic [7:0] b);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	// State byte, five data bytes and the CRC, which is corrupted on request.
	task automatic send_frame(input logic [7:0] st, input logic [39:0] pl, input bit spoil);
		logic [7:0] crc;
		logic [7:0] b;
		crc = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, st);
		send_byte(1'b1, st);
		for (int k = 4; k >= 0; k--) begin
			b   = pl[k*8 +: 8];
			crc = htfd_pkg::crc8_byte(crc, b);
			send_byte(1'b1, b);
		end
		if (spoil) begin
			crc = crc ^ 8'($urandom_range(255, 1));
		end
		send_byte(1'b1, crc);
	endtask

	// Mostly armed, complete frames; the rest is noise and cut-off frames.
	task automatic random_scenario();
		int          pick;
		logic [39:0] pl;
		logic [7:0]  st;
		pick = $urandom_range(99);
		for (int k = 0; k < 5; k++) begin
			pl[k*8 +: 8] = payload_byte();
		end
		st = 8'($urandom_range(255));
		if ($urandom_range(4) != 0) begin
			st[7] = 1'b0;
		end
		if (pick < 70) begin
			send_byte(1'b0, ready_byte());
			send_frame(st, pl, $urandom_range(4) == 0);
		end else if (pick < 78) begin
			send_byte(1'b0, not_ready_byte());
		end else if (pick < 86) begin
			send_byte(1'b1, 8'($urandom_range(255)));
		end else if (pick < 94) begin
			send_byte(1'b0, ready_byte());
			repeat ($urandom_range(6, 1)) send_byte(1'b1, 8'($urandom_range(255)));
		end else begin
			repeat (7) send_byte(1'b1, 8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int upto);
		s_idle_pct  = idle_pct;
		m_stall_pct = stall_pct;
		while (bytes_sent < upto) begin
			random_scenario();
		end
	endtask

	// Result-side readiness; a requested hold-off is counted down here.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= m_stall_pct);
			end
		end
	end

	// Ends the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = 1'b0;
		s_tdata  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray frame byte, not-ready status, restart mid-frame,
		// largest and smallest raw values, busy together with a bad CRC.
		send_byte(1'b1, 8'hAB);
		send_byte(1'b0, 8'h08);
		send_byte(1'b0, htfd_pkg::READY_MASK);
		send_byte(1'b1, 8'h1C);
		send_byte(1'b0, 8'hFF);
		send_frame(8'h1C, {40{1'b1}}, 1'b0);
		send_byte(1'b0, 8'h98);
		send_frame(8'h80, '0, 1'b1);
		send_byte(1'b0, 8'h18);
		send_frame(8'h00, '0, 1'b0);

		run_phase(0, 0, 300);

		// Long result-side hold-off while every byte asks for a result.
		s_idle_pct  = 0;
		m_stall_pct = 0;
		hold_req    = HOLD_CYCLES;
		repeat (12) send_byte(1'b0, not_ready_byte());

		run_phase(48, 0, 580);
		run_phase(0, 48, 860);
		run_phase(31, 31, 1150);
		s_tvalid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes over four idling phases and one long result hold-off.",
			bytes_sent);
		$display("Checked results: %0d ok, %0d busy, %0d crc error, %0d not ready.",
			n_ok, n_busy, n_crc, n_init);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
